FILE: src/fpalu_pkg.sv
// Shared types, opcodes and constants for the fixed-point ALU.
package fpalu_pkg;

    localparam int FRAC_BITS = 8;
    localparam int DATA_W    = 32;
    localparam int QW        = DATA_W + 1;   // quotient bits resolved by the divider
    localparam int LATENCY   = QW + 4;       // start to o_valid, in cycles

    localparam logic [DATA_W-1:0] RAW_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] RAW_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef enum logic [3:0] {
        KIND_ADD  = 4'd0,
        KIND_SUB  = 4'd1,
        KIND_MUL  = 4'd2,
        KIND_DIV  = 4'd3,
        KIND_MIN  = 4'd4,
        KIND_MAX  = 4'd5,
        KIND_INC  = 4'd6,
        KIND_DEC  = 4'd7,
        KIND_FROM = 4'd8,
        KIND_TO   = 4'd9
    } t_kind;

    typedef struct packed {
        logic              vld;
        logic [3:0]        kind;
        logic [DATA_W-1:0] ma;
        logic [DATA_W-1:0] mb;
        logic              neg;
        logic              a_neg;
        logic              less;
        logic              equal;
        logic              greater;
        logic              s_ovf;
        logic              dz;
        logic              dov;
        logic [DATA_W-1:0] s_res;
    } t_ctrl;

endpackage

FILE: src/fixed_point_alu_core.sv
// Pipelined signed fixed-point ALU: add, sub, mul, div, min, max, inc, dec, conversions.
//
// Usage:
//   Drive kind, operand_a and operand_b on i_kind, i_operand_a, i_operand_b and
//   pulse start. A transaction is accepted on each edge with start high and busy
//   low; busy is always low, so one transaction can be issued every cycle.
//   Exactly one result per transaction appears on o_result and the flag ports
//   for a single cycle, marked by o_valid, in issue order.
// Depth: fpalu_pkg::LATENCY from the accepting edge to o_valid, the same
//   for every opcode. The depth is set by the restoring divider, one quotient
//   bit per stage over 33 stages, plus input, setup, multiply, round and
//   output stages. Throughput: one transaction per cycle.
// Reset: i_rst_n is synchronous, active low, and clears every stage valid bit;
//   transactions in flight are dropped. The block holds no other state.
// The receiver cannot stall: each result is on the ports for exactly one
//   cycle and must be taken then.
module fixed_point_alu_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [3:0]  i_kind,
    input  logic signed [31:0] i_operand_a,
    input  logic signed [31:0] i_operand_b,
    output logic        o_valid,
    output logic signed [31:0] o_result,
    output logic        o_less,
    output logic        o_equal,
    output logic        o_greater,
    output logic        o_overflow,
    output logic        o_divide_by_zero
);

    localparam int DW = fpalu_pkg::DATA_W;
    localparam int QW = fpalu_pkg::QW;
    localparam int FB = fpalu_pkg::FRAC_BITS;

    assign busy = 1'b0;

    // stage 0: input register
    logic          r_in_vld;
    logic [3:0]    r_kind;
    logic [DW-1:0] r_a;
    logic [DW-1:0] r_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= start;
        end
        r_kind <= i_kind;
        r_a    <= i_operand_a;
        r_b    <= i_operand_b;
    end

    // stage 1: magnitudes, flags, simple ops, divider setup
    fpalu_pkg::t_ctrl n_c1;
    logic [2*DW-1:0] numer;
    logic [DW:0]     sum;
    logic [DW-1:0]   m_int;
    logic [QW-1:0]   n_low;
    logic [DW-1:0]   n_rem;

    always_comb begin
        n_c1       = '0;
        n_c1.vld   = r_in_vld;
        n_c1.kind  = r_kind;
        n_c1.a_neg = r_a[DW-1];
        n_c1.ma    = r_a[DW-1] ? (~r_a + 1'b1) : r_a;
        n_c1.mb    = r_b[DW-1] ? (~r_b + 1'b1) : r_b;
        n_c1.neg   = r_a[DW-1] ^ r_b[DW-1];
        n_c1.less    = $signed(r_a) < $signed(r_b);
        n_c1.equal   = r_a == r_b;
        n_c1.greater = $signed(r_a) > $signed(r_b);
        numer = {{DW{1'b0}}, n_c1.ma} << FB;
        n_low = numer[QW-1:0];
        n_rem = {1'b0, numer[2*DW-1:QW]};
        n_c1.dov = n_rem >= n_c1.mb;
        n_c1.dz  = (r_kind == fpalu_pkg::KIND_DIV) && (n_c1.mb == '0);
        m_int = n_c1.ma >> FB;
        sum   = '0;
        case (r_kind)
            fpalu_pkg::KIND_ADD: sum = {r_a[DW-1], r_a} + {r_b[DW-1], r_b};
            fpalu_pkg::KIND_SUB: sum = {r_a[DW-1], r_a} - {r_b[DW-1], r_b};
            fpalu_pkg::KIND_INC: sum = {r_a[DW-1], r_a} + (DW+1)'(1);
            fpalu_pkg::KIND_DEC: sum = {r_a[DW-1], r_a} - (DW+1)'(1);
            default:             sum = '0;
        endcase
        case (r_kind)
            fpalu_pkg::KIND_ADD, fpalu_pkg::KIND_SUB,
            fpalu_pkg::KIND_INC, fpalu_pkg::KIND_DEC: begin
                if (sum[DW] != sum[DW-1]) begin
                    n_c1.s_ovf = 1'b1;
                    n_c1.s_res = sum[DW] ? fpalu_pkg::RAW_MIN : fpalu_pkg::RAW_MAX;
                end else begin
                    n_c1.s_res = sum[DW-1:0];
                end
            end
            fpalu_pkg::KIND_MIN: n_c1.s_res = n_c1.less ? r_a : r_b;
            fpalu_pkg::KIND_MAX: n_c1.s_res = n_c1.greater ? r_a : r_b;
            fpalu_pkg::KIND_FROM: begin
                if (r_a[DW-1]) begin
                    if (numer > {{DW{1'b0}}, fpalu_pkg::RAW_MIN}) begin
                        n_c1.s_ovf = 1'b1;
                        n_c1.s_res = fpalu_pkg::RAW_MIN;
                    end else begin
                        n_c1.s_res = ~numer[DW-1:0] + 1'b1;
                    end
                end else if (numer > {{DW{1'b0}}, fpalu_pkg::RAW_MAX}) begin
                    n_c1.s_ovf = 1'b1;
                    n_c1.s_res = fpalu_pkg::RAW_MAX;
                end else begin
                    n_c1.s_res = numer[DW-1:0];
                end
            end
            fpalu_pkg::KIND_TO: n_c1.s_res = r_a[DW-1] ? (~m_int + 1'b1) : m_int;
            default:            n_c1.s_res = '0;
        endcase
    end

    // divider pipeline: index 0 is the stage 1 register
    fpalu_pkg::t_ctrl r_c   [0:QW];
    logic [DW-1:0]    r_rem [0:QW];
    logic [QW-1:0]    r_q   [0:QW];
    logic [QW-1:0]    r_low [0:QW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c[0].vld <= 1'b0;
        end else begin
            r_c[0] <= n_c1;
        end
        r_rem[0] <= n_rem;
        r_q[0]   <= '0;
        r_low[0] <= n_low;
    end

    for (genvar gi = 0; gi < QW; gi++) begin : g_div
        logic [DW:0] trial;
        logic [DW:0] diff;
        logic        ge;

        always_comb begin
            trial = {r_rem[gi], r_low[gi][QW-1]};
            diff  = trial - {1'b0, r_c[gi].mb};
            ge    = trial >= {1'b0, r_c[gi].mb};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_c[gi+1].vld <= 1'b0;
            end else begin
                r_c[gi+1] <= r_c[gi];
            end
            r_rem[gi+1] <= ge ? diff[DW-1:0] : trial[DW-1:0];
            r_q[gi+1]   <= {r_q[gi][QW-2:0], ge};
            r_low[gi+1] <= {r_low[gi][QW-2:0], 1'b0};
        end
    end

    // stage X: multiply, round quotient
    fpalu_pkg::t_ctrl r_cx;
    logic [2*DW-1:0]  r_p;
    logic [QW:0]      r_qx;
    logic [DW-1:0]    rem_gap;

    assign rem_gap = r_c[QW].mb - r_rem[QW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx.vld <= 1'b0;
        end else begin
            r_cx <= r_c[QW];
        end
        r_p  <= r_c[QW].ma * r_c[QW].mb;
        r_qx <= {1'b0, r_q[QW]} + (QW+1)'(r_rem[QW] >= rem_gap);
    end

    // stage Y: product rounding
    fpalu_pkg::t_ctrl r_cy;
    logic [2*DW-1:0]  r_m;
    logic [QW:0]      r_qy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cy.vld <= 1'b0;
        end else begin
            r_cy <= r_cx;
        end
        r_m  <= (r_p + ((2*DW)'(1) << (FB - 1))) >> FB;
        r_qy <= r_qx;
    end

    // stage Z: clamp, select, output register
    logic [2*DW-1:0] mag;
    logic [DW-1:0]   n_res;
    logic            n_ovf;

    always_comb begin
        mag   = '0;
        n_res = r_cy.s_res;
        n_ovf = r_cy.s_ovf;
        case (r_cy.kind)
            fpalu_pkg::KIND_MUL, fpalu_pkg::KIND_DIV: begin
                mag = (r_cy.kind == fpalu_pkg::KIND_MUL) ? r_m
                                                         : {{(2*DW-QW-1){1'b0}}, r_qy};
                n_ovf = 1'b0;
                if (r_cy.neg) begin
                    if (r_cy.dov || mag > {{DW{1'b0}}, fpalu_pkg::RAW_MIN}) begin
                        n_ovf = 1'b1;
                        n_res = fpalu_pkg::RAW_MIN;
                    end else begin
                        n_res = ~mag[DW-1:0] + 1'b1;
                    end
                end else if (r_cy.dov || mag > {{DW{1'b0}}, fpalu_pkg::RAW_MAX}) begin
                    n_ovf = 1'b1;
                    n_res = fpalu_pkg::RAW_MAX;
                end else begin
                    n_res = mag[DW-1:0];
                end
                if (r_cy.kind == fpalu_pkg::KIND_MUL) begin
                    if (r_cy.neg && mag <= {{DW{1'b0}}, fpalu_pkg::RAW_MIN}) begin
                        n_ovf = 1'b0;
                        n_res = ~mag[DW-1:0] + 1'b1;
                    end else if (!r_cy.neg && mag <= {{DW{1'b0}}, fpalu_pkg::RAW_MAX}) begin
                        n_ovf = 1'b0;
                        n_res = mag[DW-1:0];
                    end
                end
                if (r_cy.dz) begin
                    n_ovf = 1'b0;
                    n_res = r_cy.a_neg ? fpalu_pkg::RAW_MIN : fpalu_pkg::RAW_MAX;
                end
            end
            default: begin
                n_res = r_cy.s_res;
                n_ovf = r_cy.s_ovf;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_cy.vld;
        end
        o_result         <= n_res;
        o_less           <= r_cy.less;
        o_equal          <= r_cy.equal;
        o_greater        <= r_cy.greater;
        o_overflow       <= n_ovf;
        o_divide_by_zero <= r_cy.dz;
    end

    // each accepted start must be followed by o_valid as the LATENCY parameter sets
    a_latency : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##(fpalu_pkg::LATENCY + 1) o_valid)
        else $error("transaction result missing at expected latency");

    a_one_flag : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $onehot({o_less, o_equal, o_greater}))
        else $error("compare flags not exclusive");

    a_dz_no_ovf : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_divide_by_zero) |-> !o_overflow)
        else $error("divide by zero also flagged overflow");

    a_ovf_sat : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_overflow) |->
            (o_result == fpalu_pkg::RAW_MAX || o_result == fpalu_pkg::RAW_MIN))
        else $error("overflow without saturated result");

endmodule

FILE: tb/fixed_point_alu_core_tb.sv
// Self-checking testbench for the pipelined fixed-point ALU core.
module fixed_point_alu_core_tb;

    typedef struct {
        logic [31:0] result;
        logic        less;
        logic        equal;
        logic        greater;
        logic        overflow;
        logic        divide_by_zero;
    } t_alu_out;

    localparam int CYCLE_LIMIT = 400000;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [3:0]  i_kind;
    logic signed [31:0] i_operand_a;
    logic signed [31:0] i_operand_b;
    logic        o_valid;
    logic signed [31:0] o_result;
    logic        o_less;
    logic        o_equal;
    logic        o_greater;
    logic        o_overflow;
    logic        o_divide_by_zero;

    t_alu_out alu_expected_q[$];
    int       error_count;
    int       cycle_count;
    int       send_idle_pct;

    fixed_point_alu_core u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_kind(i_kind), .i_operand_a(i_operand_a), .i_operand_b(i_operand_b),
        .o_valid(o_valid), .o_result(o_result), .o_less(o_less),
        .o_equal(o_equal), .o_greater(o_greater), .o_overflow(o_overflow),
        .o_divide_by_zero(o_divide_by_zero)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic [31:0] clamp64(longint v, ref logic ovf);
        if (v > 64'sd2147483647) begin
            ovf = 1'b1;
            return fpalu_pkg::RAW_MAX;
        end
        if (v < -64'sd2147483648) begin
            ovf = 1'b1;
            return fpalu_pkg::RAW_MIN;
        end
        return v[31:0];
    endfunction

    function automatic t_alu_out alu_compute(logic [3:0] kind, logic signed [31:0] a,
                                             logic signed [31:0] b);
        t_alu_out   r;
        longint     la, lb, mag, quo, rem;
        logic [63:0] prod;
        logic       ovf;
        logic       neg;
        la  = a;
        lb  = b;
        ovf = 1'b0;
        neg = (a < 0) != (b < 0);
        r.divide_by_zero = 1'b0;
        r.result = '0;
        case (kind)
            fpalu_pkg::KIND_ADD: r.result = clamp64(la + lb, ovf);
            fpalu_pkg::KIND_SUB: r.result = clamp64(la - lb, ovf);
            fpalu_pkg::KIND_MUL: begin
                prod = 64'(la < 0 ? -la : la) * 64'(lb < 0 ? -lb : lb);
                prod = (prod + (64'd1 << (fpalu_pkg::FRAC_BITS - 1))) >> fpalu_pkg::FRAC_BITS;
                mag = longint'(prod);
                r.result = clamp64(neg ? -mag : mag, ovf);
            end
            fpalu_pkg::KIND_DIV: begin
                if (b == 0) begin
                    r.divide_by_zero = 1'b1;
                    r.result = (a < 0) ? fpalu_pkg::RAW_MIN : fpalu_pkg::RAW_MAX;
                end else begin
                    mag = (la < 0 ? -la : la) <<< fpalu_pkg::FRAC_BITS;
                    quo = mag / (lb < 0 ? -lb : lb);
                    rem = mag % (lb < 0 ? -lb : lb);
                    if (rem >= (lb < 0 ? -lb : lb) - rem) quo++;
                    r.result = clamp64(neg ? -quo : quo, ovf);
                end
            end
            fpalu_pkg::KIND_MIN: r.result = (a < b) ? a : b;
            fpalu_pkg::KIND_MAX: r.result = (a > b) ? a : b;
            fpalu_pkg::KIND_INC: r.result = clamp64(la + 1, ovf);
            fpalu_pkg::KIND_DEC: r.result = clamp64(la - 1, ovf);
            fpalu_pkg::KIND_FROM: r.result = clamp64(la <<< fpalu_pkg::FRAC_BITS, ovf);
            fpalu_pkg::KIND_TO: begin
                mag = (la < 0 ? -la : la) >>> fpalu_pkg::FRAC_BITS;
                r.result = (a < 0) ? -mag : mag;
            end
            default: r.result = '0;
        endcase
        r.overflow = ovf;
        r.less     = a < b;
        r.equal    = a == b;
        r.greater  = a > b;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycle_count);
        error_count++;
    endtask

    task automatic send_op(logic [3:0] kind, logic [31:0] a, logic [31:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start       <= 1'b1;
        i_kind      <= kind;
        i_operand_a <= a;
        i_operand_b <= b;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        alu_expected_q.push_back(alu_compute(kind, a, b));
    endtask

    always @(posedge i_clk) begin
        t_alu_out e;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
        if (i_rst_n && o_valid) begin
            if (alu_expected_q.size() == 0) begin
                report_mismatch("unexpected transaction", o_result, '0);
            end else begin
                e = alu_expected_q.pop_front();
                if (o_result !== e.result) report_mismatch("result", o_result, e.result);
                if (o_less !== e.less) report_mismatch("less", o_less, e.less);
                if (o_equal !== e.equal) report_mismatch("equal", o_equal, e.equal);
                if (o_greater !== e.greater) report_mismatch("greater", o_greater, e.greater);
                if (o_overflow !== e.overflow)
                    report_mismatch("overflow", o_overflow, e.overflow);
                if (o_divide_by_zero !== e.divide_by_zero)
                    report_mismatch("divide_by_zero", o_divide_by_zero, e.divide_by_zero);
            end
        end
    end

    function automatic logic [31:0] rand_operand();
        case ($urandom_range(5))
            0: return fpalu_pkg::RAW_MAX - $urandom_range(3);
            1: return fpalu_pkg::RAW_MIN + $urandom_range(3);
            2: return $urandom_range(600) - 300;
            3: return ($urandom_range(2000) - 1000) << fpalu_pkg::FRAC_BITS;
            4: return $urandom >> $urandom_range(31);
            default: return $urandom;
        endcase
    endfunction

    task automatic test_directed();
        logic [31:0] edge_vals[7];
        edge_vals = '{32'h0, 32'h1, 32'hFFFF_FFFF, fpalu_pkg::RAW_MAX, fpalu_pkg::RAW_MIN,
                      32'h100, 32'hFFFF_FF00};
        for (int k = 0; k < 16; k++)
            send_op(4'(k), fpalu_pkg::RAW_MAX, fpalu_pkg::RAW_MIN);
        send_op(fpalu_pkg::KIND_DIV, 32'h500, 32'h0);
        send_op(fpalu_pkg::KIND_DIV, 32'hFFFF_FB00, 32'h0);
        send_op(fpalu_pkg::KIND_MUL, 32'h180, 32'h1);
        send_op(fpalu_pkg::KIND_MUL, 32'hFFFF_FE80, 32'h1);
        send_op(fpalu_pkg::KIND_DIV, 32'h1, 32'h200);
        send_op(fpalu_pkg::KIND_MIN, 32'h77, 32'h77);
        send_op(fpalu_pkg::KIND_TO, 32'hFFFF_FE80, 32'h0);
        for (int k = 0; k < 3; k++)
            send_op(fpalu_pkg::KIND_SUB, edge_vals[k + 2], edge_vals[k + 4]);
    endtask

    task automatic test_random(int count, int idle_pct);
        send_idle_pct = idle_pct;
        repeat (count) send_op(4'($urandom_range(15) < 14 ? $urandom_range(9) : $urandom_range(15)),
                               rand_operand(), rand_operand());
        send_idle_pct = 0;
    endtask

    task automatic test_drain();
        int guard;
        guard = 0;
        start <= 1'b0;
        while (alu_expected_q.size() != 0 && guard < 10 * fpalu_pkg::LATENCY) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (fpalu_pkg::LATENCY + 4) @(posedge i_clk);
    endtask

    initial begin
        error_count   = 0;
        cycle_count   = 0;
        send_idle_pct = 0;
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_kind        = '0;
        i_operand_a   = '0;
        i_operand_b   = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(350, 0);
        test_random(300, 68);
        test_random(300, 31);
        test_random(350, 0);
        test_drain();
        if (error_count == 0 && alu_expected_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule

FILE: filelist.f
src/fpalu_pkg.sv
src/fixed_point_alu_core.sv
tb/fixed_point_alu_core_tb.sv
